// ===== src/fmd_pkg.sv =====
// ----------------------------------------------------------------------------
// fmd_pkg
// Shared types and constants for the FIX message deframer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fmd_pkg;

  // framing characters
  localparam logic [7:0] CH_SOH   = 8'h01;
  localparam logic [7:0] CH_EIGHT = 8'h38;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_EQ    = 8'h3D;

  // parser phase codes
  localparam logic [2:0] PH_HUNT     = 3'd0;
  localparam logic [2:0] PH_SEEK_LEN = 3'd1;
  localparam logic [2:0] PH_LEN      = 3'd2;
  localparam logic [2:0] PH_BODY     = 3'd3;
  localparam logic [2:0] PH_TRAILER  = 3'd4;
  localparam logic [2:0] PH_CHECKSUM = 3'd5;

  // abort reason codes
  localparam logic [1:0] AB_NONE     = 2'd0;
  localparam logic [1:0] AB_BAD_LEN  = 2'd1;
  localparam logic [1:0] AB_TOO_LONG = 2'd2;

  // width of the max body length register
  localparam int unsigned MAXLEN_W = 20;

  // result queue depth
  localparam int unsigned RQ_DEPTH = 4;
  localparam int unsigned RQ_PTR_W = $clog2(RQ_DEPTH);
  localparam int unsigned RQ_CNT_W = $clog2(RQ_DEPTH + 1);

  // push counts
  localparam logic [1:0] PUSH_NONE = 2'd0;
  localparam logic [1:0] PUSH_ONE  = 2'd1;
  localparam logic [1:0] PUSH_TWO  = 2'd2;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       message_start;
    logic       message_end;
    logic       abort_flag;
    logic [1:0] abort_reason;
  } fmd_result_t;

  typedef struct packed {
    logic [1:0]  cnt;
    fmd_result_t r0;
    fmd_result_t r1;
  } fmd_push_t;

endpackage

`default_nettype wire

// ===== src/fmd_if.sv =====
// ----------------------------------------------------------------------------
// fmd_if
// Valid/ready channel interfaces for the deframer input and result streams.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface fmd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface fmd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       message_start;
  logic       message_end;
  logic       abort_flag;
  logic [1:0] abort_reason;

  modport source (output valid, output out_byte, output message_start,
                  output message_end, output abort_flag, output abort_reason,
                  input ready);
  modport sink   (input valid, input out_byte, input message_start,
                  input message_end, input abort_flag, input abort_reason,
                  output ready);
endinterface

`default_nettype wire

// ===== src/fmd_parser.sv =====
// ----------------------------------------------------------------------------
// fmd_parser
// Framing state machine: hunts for the start, tracks the body length field,
// counts body bytes and matches the checksum tag. Emits up to two results
// per accepted item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fmd_parser
  import fmd_pkg::*;
#(
  parameter int unsigned LENGTH_BITS = 20
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                accept,
  input  wire logic [7:0]          data_byte,
  input  wire logic [MAXLEN_W-1:0] max_len,
  output fmd_push_t                push
);

  localparam int unsigned LV_W   = LENGTH_BITS + 1;
  localparam int unsigned PROD_W = LENGTH_BITS + 5;
  localparam int unsigned CMP_W  = (LV_W > MAXLEN_W) ? LV_W : MAXLEN_W;
  localparam logic [LV_W-1:0] LEN_CAP = {1'b1, {LENGTH_BITS{1'b0}}};

  logic [2:0]             phase_r, phase_nxt;
  logic [1:0]             prog_r, prog_nxt;
  logic [LV_W-1:0]        len_r, len_nxt;
  logic                   seen_r, seen_nxt;
  logic                   bad_r, bad_nxt;
  logic [LENGTH_BITS-1:0] rem_r, rem_nxt;

  logic                   is_soh;
  logic                   is_digit;
  logic [PROD_W-1:0]      prod;
  logic [LENGTH_BITS-1:0] rem_dec;
  logic                   len_over;

  fmd_result_t            pass_res;

  // byte classes and length arithmetic
  always_comb begin
    is_soh   = (data_byte == CH_SOH);
    is_digit = (data_byte >= CH_ZERO) && (data_byte <= CH_NINE);
    prod     = PROD_W'({len_r, 3'b000}) + PROD_W'({len_r, 1'b0}) +
               PROD_W'(data_byte[3:0]);
    rem_dec  = (rem_r != '0) ? rem_r - LENGTH_BITS'(1) : rem_r;
    len_over = CMP_W'(len_r) > CMP_W'(max_len);
  end

  // plain pass-through result
  always_comb begin
    pass_res               = '0;
    pass_res.out_byte      = data_byte;
    pass_res.abort_reason  = AB_NONE;
  end

  // next state and results
  always_comb begin
    phase_nxt = phase_r;
    prog_nxt  = prog_r;
    len_nxt   = len_r;
    seen_nxt  = seen_r;
    bad_nxt   = bad_r;
    rem_nxt   = rem_r;
    push      = '0;
    push.cnt  = PUSH_NONE;
    push.r0   = pass_res;
    push.r1   = pass_res;

    case (phase_r)
      PH_SEEK_LEN: begin
        push.cnt = PUSH_ONE;
        if (is_soh) begin
          prog_nxt = 2'd1;
        end else if (data_byte == CH_NINE && prog_r == 2'd1) begin
          prog_nxt = 2'd2;
        end else if (data_byte == CH_EQ && prog_r == 2'd2) begin
          phase_nxt = PH_LEN;
          prog_nxt  = 2'd0;
          len_nxt   = '0;
          seen_nxt  = 1'b0;
          bad_nxt   = 1'b0;
        end else begin
          prog_nxt = 2'd0;
        end
      end

      PH_LEN: begin
        push.cnt = PUSH_ONE;
        if (is_soh) begin
          if (bad_r || !seen_r || len_over) begin
            push.r0.abort_flag   = 1'b1;
            push.r0.abort_reason = (bad_r || !seen_r) ? AB_BAD_LEN : AB_TOO_LONG;
            phase_nxt = PH_HUNT;
            prog_nxt  = 2'd0;
            len_nxt   = '0;
            seen_nxt  = 1'b0;
            bad_nxt   = 1'b0;
            rem_nxt   = '0;
          end else if (len_r == '0) begin
            phase_nxt = PH_TRAILER;
            prog_nxt  = 2'd1;
          end else begin
            phase_nxt = PH_BODY;
            rem_nxt   = len_r[LENGTH_BITS-1:0];
            prog_nxt  = 2'd0;
          end
        end else if (is_digit) begin
          seen_nxt = 1'b1;
          len_nxt  = (prod > PROD_W'(LEN_CAP)) ? LEN_CAP : prod[LV_W-1:0];
        end else begin
          bad_nxt = 1'b1;
        end
      end

      PH_BODY: begin
        push.cnt = PUSH_ONE;
        rem_nxt  = rem_dec;
        if (rem_dec == '0) begin
          phase_nxt = PH_TRAILER;
          prog_nxt  = is_soh ? 2'd1 : 2'd0;
        end
      end

      PH_TRAILER: begin
        push.cnt = PUSH_ONE;
        if (is_soh) begin
          prog_nxt = 2'd1;
        end else if (data_byte == CH_ONE && prog_r == 2'd1) begin
          prog_nxt = 2'd2;
        end else if (data_byte == CH_ZERO && prog_r == 2'd2) begin
          prog_nxt = 2'd3;
        end else if (data_byte == CH_EQ && prog_r == 2'd3) begin
          phase_nxt = PH_CHECKSUM;
          prog_nxt  = 2'd0;
        end else begin
          prog_nxt = 2'd0;
        end
      end

      PH_CHECKSUM: begin
        push.cnt = PUSH_ONE;
        if (is_soh) begin
          push.r0.message_end = 1'b1;
          phase_nxt = PH_HUNT;
          prog_nxt  = 2'd0;
          len_nxt   = '0;
          seen_nxt  = 1'b0;
          bad_nxt   = 1'b0;
          rem_nxt   = '0;
        end
      end

      default: begin
        // hunting, also for unused phase codes
        if (data_byte == CH_EQ && prog_r == 2'd1) begin
          push.cnt              = PUSH_TWO;
          push.r0.out_byte      = CH_EIGHT;
          push.r0.message_start = 1'b1;
          push.r1.out_byte      = CH_EQ;
          phase_nxt = PH_SEEK_LEN;
          prog_nxt  = 2'd0;
        end else begin
          phase_nxt = PH_HUNT;
          prog_nxt  = (data_byte == CH_EIGHT) ? 2'd1 : 2'd0;
        end
      end
    endcase

    if (!accept) begin
      push.cnt = PUSH_NONE;
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      prog_r  <= 2'd0;
      len_r   <= '0;
      seen_r  <= 1'b0;
      bad_r   <= 1'b0;
      rem_r   <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      prog_r  <= prog_nxt;
      len_r   <= len_nxt;
      seen_r  <= seen_nxt;
      bad_r   <= bad_nxt;
      rem_r   <= rem_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== src/fmd_result_q.sv =====
// ----------------------------------------------------------------------------
// fmd_result_q
// Small result queue: takes up to two results per cycle, delivers one while out_ready is high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fmd_result_q
  import fmd_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire fmd_push_t push,
  output logic           space_ok,
  output logic           out_valid,
  input  wire logic      out_ready,
  output fmd_result_t    out_res
);

  fmd_result_t         ent_r [RQ_DEPTH];
  logic [RQ_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [RQ_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [RQ_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [RQ_PTR_W-1:0] wr_ptr_p1;
  logic                pop;

  // status and pointer update
  always_comb begin
    out_valid  = (cnt_r != '0);
    out_res    = ent_r[rd_ptr_r];
    space_ok   = (cnt_r <= RQ_CNT_W'(RQ_DEPTH - 2));
    pop        = out_valid && out_ready;
    wr_ptr_p1  = wr_ptr_r + RQ_PTR_W'(1);
    wr_ptr_nxt = wr_ptr_r + RQ_PTR_W'(push.cnt);
    rd_ptr_nxt = pop ? rd_ptr_r + RQ_PTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r + RQ_CNT_W'(push.cnt) - RQ_CNT_W'(pop);
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push.cnt != PUSH_NONE) begin
      ent_r[wr_ptr_r] <= push.r0;
    end
    if (push.cnt == PUSH_TWO) begin
      ent_r[wr_ptr_p1] <= push.r1;
    end
  end

endmodule

`default_nettype wire

// ===== src/fix_message_deframer_top.sv =====
// ----------------------------------------------------------------------------
// fix_message_deframer_top
// FIX tag-value message deframer: byte stream in, marked message bytes out.
// ----------------------------------------------------------------------------
// results are written into the result queue as their item is accepted and offered from its head
// throughput: one item per cycle while input ready is high; the item completing "8="
//   yields two results that drain through a four-entry result queue
// input ready stays high while the queue holds two or fewer results
// reset: synchronous active-low rst_n returns the parser to hunting, empties
//   the queue and sets max_body_length to its full-scale value
`timescale 1ns / 1ps
`default_nettype none

module fix_message_deframer_top
  import fmd_pkg::*;
#(
  parameter int unsigned LENGTH_BITS = 20
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  fmd_in_if.sink                   in_ch,
  fmd_out_if.source                out_ch,
  input  wire logic                cfg_we,
  input  wire logic [MAXLEN_W-1:0] cfg_wdata
);

  localparam logic [MAXLEN_W-1:0] MAX_MASK =
    (LENGTH_BITS >= MAXLEN_W) ? {MAXLEN_W{1'b1}}
                              : MAXLEN_W'((64'd1 << LENGTH_BITS) - 64'd1);

  logic [MAXLEN_W-1:0] max_len_r;
  logic                accept;
  logic                space_ok;
  fmd_push_t           push;
  fmd_result_t         out_res;

  // max body length register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= MAX_MASK;
    end else if (cfg_we) begin
      max_len_r <= cfg_wdata & MAX_MASK;
    end
  end

  // input handshake
  assign in_ch.ready = space_ok;
  assign accept      = in_ch.valid && space_ok;

  fmd_parser #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .data_byte (in_ch.data_byte),
    .max_len   (max_len_r),
    .push      (push)
  );

  fmd_result_q u_result_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .space_ok  (space_ok),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_res   (out_res)
  );

  // result payload
  assign out_ch.out_byte      = out_res.out_byte;
  assign out_ch.message_start = out_res.message_start;
  assign out_ch.message_end   = out_res.message_end;
  assign out_ch.abort_flag    = out_res.abort_flag;
  assign out_ch.abort_reason  = out_res.abort_reason;

endmodule

`default_nettype wire

// ===== src/fmd_checker.sv =====
// ----------------------------------------------------------------------------
// fmd_checker
// Port-level checks on the deframer result stream, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fmd_checker
  import fmd_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_byte,
  input wire logic       message_start,
  input wire logic       message_end,
  input wire logic       abort_flag,
  input wire logic [1:0] abort_reason
);

  // no result is offered right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered right after reset");

  // a stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) &&
      $stable(abort_flag) && $stable(message_end))
    else $error("stalled result changed");

  // abort flag and reason agree
  a_abort_reason: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (abort_flag == (abort_reason != AB_NONE)) &&
      (abort_reason == AB_NONE || abort_reason == AB_BAD_LEN ||
       abort_reason == AB_TOO_LONG))
    else $error("abort flag and reason disagree");

  // start mark only on the '8', never with end or abort
  a_start_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && message_start |-> out_byte == CH_EIGHT && !message_end &&
      !abort_flag)
    else $error("bad message start result");

  // end mark and abort only on an SOH
  a_end_soh: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (message_end || abort_flag) |-> out_byte == CH_SOH &&
      !(message_end && abort_flag))
    else $error("bad message end or abort result");

endmodule

bind fix_message_deframer_top fmd_checker u_fmd_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_byte      (out_ch.out_byte),
  .message_start (out_ch.message_start),
  .message_end   (out_ch.message_end),
  .abort_flag    (out_ch.abort_flag),
  .abort_reason  (out_ch.abort_reason)
);

`default_nettype wire
